// ===== design/ethernet_tx_scheduler_ifg_macros.svh =====
// Assertion macros used by the checker file etx_checker.sv.
`ifndef ETHERNET_TX_SCHEDULER_IFG_MACROS_SVH
`define ETHERNET_TX_SCHEDULER_IFG_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("etx assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ETX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("etx assertion failed");

`endif

// ===== design/etx_pkg.sv =====
package etx_pkg;

  localparam int unsigned TagW  = 8;
  localparam int unsigned BitsW = 16;
  localparam int unsigned TpbW  = 8;
  localparam int unsigned LenW  = 5;

  localparam logic [BitsW-1:0] GapBits = 16'd96;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_UPPER   = 2'd1,
    OP_CHANNEL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_SENT = 2'd1,
    EV_UP   = 2'd2,
    EV_DROP = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    TXS_IDLE = 2'd0,
    TXS_TX   = 2'd1,
    TXS_GAP  = 2'd2
  } txs_e;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_TX   = 3'b010,
    MODE_GAP  = 3'b100
  } mode_e;

  typedef struct packed {
    logic [BitsW-1:0] bits;
    logic [TagW-1:0]  tag;
  } qentry_t;

  typedef struct packed {
    logic    push;
    logic    pop;
    qentry_t wdata;
  } qctl_t;

  function automatic txs_e mode_code(mode_e m);
    txs_e c;
    case (m)
      MODE_TX:  c = TXS_TX;
      MODE_GAP: c = TXS_GAP;
      default:  c = TXS_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ===== design/etx_ram.sv =====
module etx_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/etx_queue.sv =====
module etx_queue #(
  parameter int unsigned Depth = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  etx_pkg::qctl_t             ctl_i,
  output etx_pkg::qentry_t           head_o,
  output logic [$clog2(Depth+1)-1:0] count_o,
  output logic [$clog2(Depth+1)-1:0] count_next_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [AddrW-1:0] head_q, head_d, head_inc, tail;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW:0]   head_sum, tail_sum;
  logic             we;
  logic             bypass_q, bypass_d;
  etx_pkg::qentry_t byp_data_q;
  etx_pkg::qentry_t ram_rdata;

  assign head_sum = (AddrW+1)'(head_q) + (AddrW+1)'(1);
  assign head_inc = (head_sum == (AddrW+1)'(Depth)) ? '0 : head_sum[AddrW-1:0];

  assign tail_sum = (AddrW+1)'(head_q) + (AddrW+1)'(count_q);
  assign tail = (tail_sum >= (AddrW+1)'(Depth)) ?
                AddrW'(tail_sum - (AddrW+1)'(Depth)) : tail_sum[AddrW-1:0];

  // A push that is popped in the same transaction never touches storage.
  assign we     = ctl_i.push && !ctl_i.pop;
  assign head_d = ctl_i.pop ? head_inc : head_q;

  always_comb begin
    count_d = count_q;
    if (ctl_i.push && !ctl_i.pop) begin
      count_d = count_q + CntW'(1);
    end else if (ctl_i.pop && !ctl_i.push) begin
      count_d = count_q - CntW'(1);
    end
  end

  // The RAM read is old data on a same-address write, so forward the write.
  assign bypass_d = we && (tail == head_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      bypass_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      bypass_q <= bypass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= ctl_i.wdata;
  end

  etx_ram #(
    .Width($bits(etx_pkg::qentry_t)),
    .Depth(Depth)
  ) u_etx_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(tail),
    .wdata_i(ctl_i.wdata),
    .raddr_i(head_d),
    .rdata_o(ram_rdata)
  );

  assign head_o       = bypass_q ? byp_data_q : ram_rdata;
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

// ===== design/ethernet_tx_scheduler_ifg.sv =====
// Full-duplex Ethernet transmit scheduler with interframe gap.
// Input transactions arrive on the s_axis channel. tuser selects the kind:
// a clock tick, a frame from the upper layer (tag and bit length) or a frame
// from the channel (tag and bit error flag). Upper layer frames wait in a
// FIFO of QUEUE_DEPTH entries; a frame that finds it full is dropped.
// Each input transaction produces exactly one m_axis transaction: the event
// code in tuser, and the event tag, queue length and transmitter state after
// the transaction in tdata.
// The work for one transaction is done in the cycle it is accepted, and the
// result is registered, so it is shown in the next cycle and one transaction
// can be accepted every cycle unless the receiver stalls. The head of the
// queue is read from a RAM with a registered read port, addressed ahead
// with the next head pointer. The bit time in clock ticks is set through
// cfg_we_i and cfg_wdata_i. The user must write it only while the block is
// idle, which the block does not enforce. Reset empties the queue, sets the
// transmitter idle and the bit time to one tick. When the receiver stalls, the
// result stays in the output register and s_axis_tready drops until it is taken.
module ethernet_tx_scheduler_ifg #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_tag [7:0], frame_bits [23:8], bit_error [24], zero [31:25]
  input  logic [31:0] s_axis_tdata,
  // op [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // event_tag [7:0], queue_length [12:8], tx_state [14:13], zero [15]
  output logic [15:0] m_axis_tdata,
  // event_res [1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [etx_pkg::TpbW-1:0]  tpb_q, tpb;
  etx_pkg::mode_e            mode_q, mode_d;
  logic [etx_pkg::BitsW-1:0] bits_rem_q, bits_rem_d;
  logic [etx_pkg::TpbW-1:0]  phase_q, phase_d;
  logic [etx_pkg::TagW-1:0]  cur_tag_q, cur_tag_d;

  logic                      out_valid_q;
  etx_pkg::ev_e              out_ev_q, ev_d;
  logic [etx_pkg::TagW-1:0]  out_tag_q, ev_tag_d;
  logic [etx_pkg::LenW-1:0]  out_len_q;
  etx_pkg::txs_e             out_txs_q;

  logic                      accept;
  etx_pkg::op_e              in_op;
  logic [etx_pkg::TagW-1:0]  in_tag;
  logic [etx_pkg::BitsW-1:0] in_bits;
  logic                      in_err;

  logic [etx_pkg::TpbW-1:0]  phase_inc, tick_phase;
  logic [etx_pkg::BitsW-1:0] tick_bits;
  logic                      bit_end, tick_done;

  etx_pkg::qctl_t            qctl;
  etx_pkg::qentry_t          qhead;
  logic [CntW-1:0]           qcount, qcount_next;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_op   = etx_pkg::op_e'(s_axis_tuser);
  assign in_tag  = s_axis_tdata[7:0];
  assign in_bits = s_axis_tdata[23:8];
  assign in_err  = s_axis_tdata[24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q <= 8'd1;
    end else if (cfg_we_i) begin
      tpb_q <= cfg_wdata_i;
    end
  end

  assign tpb = (tpb_q == '0) ? 8'd1 : tpb_q;

  // One tick of the bit-time countdown.
  assign phase_inc  = phase_q + 8'd1;
  assign bit_end    = phase_inc >= tpb;
  assign tick_done  = (bits_rem_q == '0) || (bit_end && (bits_rem_q == 16'd1));
  assign tick_bits  = bit_end ? bits_rem_q - 16'd1 : bits_rem_q;
  assign tick_phase = bit_end ? '0 : phase_inc;

  always_comb begin
    mode_d      = mode_q;
    bits_rem_d  = bits_rem_q;
    phase_d     = phase_q;
    cur_tag_d   = cur_tag_q;
    ev_d        = etx_pkg::EV_NONE;
    ev_tag_d    = '0;
    qctl.push   = 1'b0;
    qctl.pop    = 1'b0;
    qctl.wdata  = '{bits: in_bits, tag: in_tag};
    if (accept) begin
      case (in_op)
        etx_pkg::OP_TICK: begin
          case (mode_q)
            etx_pkg::MODE_TX: begin
              if (tick_done) begin
                ev_d       = etx_pkg::EV_SENT;
                ev_tag_d   = cur_tag_q;
                mode_d     = etx_pkg::MODE_GAP;
                bits_rem_d = etx_pkg::GapBits;
                phase_d    = '0;
              end else begin
                bits_rem_d = tick_bits;
                phase_d    = tick_phase;
              end
            end
            etx_pkg::MODE_GAP: begin
              if (!tick_done) begin
                bits_rem_d = tick_bits;
                phase_d    = tick_phase;
              end else if (qcount != '0) begin
                qctl.pop   = 1'b1;
                cur_tag_d  = qhead.tag;
                bits_rem_d = qhead.bits;
                phase_d    = '0;
                mode_d     = etx_pkg::MODE_TX;
              end else begin
                bits_rem_d = '0;
                phase_d    = '0;
                mode_d     = etx_pkg::MODE_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
        etx_pkg::OP_UPPER: begin
          if (qcount == CntW'(QUEUE_DEPTH)) begin
            ev_d     = etx_pkg::EV_DROP;
            ev_tag_d = in_tag;
          end else begin
            qctl.push = 1'b1;
            if (mode_q == etx_pkg::MODE_IDLE) begin
              qctl.pop   = 1'b1;
              cur_tag_d  = in_tag;
              bits_rem_d = in_bits;
              phase_d    = '0;
              mode_d     = etx_pkg::MODE_TX;
            end
          end
        end
        etx_pkg::OP_CHANNEL: begin
          if (!in_err) begin
            ev_d     = etx_pkg::EV_UP;
            ev_tag_d = in_tag;
          end
        end
        default: begin
        end
      endcase
    end
  end

  etx_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_etx_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (qctl),
    .head_o      (qhead),
    .count_o     (qcount),
    .count_next_o(qcount_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= etx_pkg::MODE_IDLE;
      bits_rem_q  <= '0;
      phase_q     <= '0;
      cur_tag_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      bits_rem_q <= bits_rem_d;
      phase_q    <= phase_d;
      cur_tag_q  <= cur_tag_d;
      if (s_axis_tready) begin
        out_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_ev_q  <= ev_d;
      out_tag_q <= ev_tag_d;
      out_len_q <= etx_pkg::LenW'(qcount_next);
      out_txs_q <= etx_pkg::mode_code(mode_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_txs_q, out_len_q, out_tag_q};
  assign m_axis_tuser  = out_ev_q;

endmodule

// ===== design/etx_checker.sv =====
`include "ethernet_tx_scheduler_ifg_macros.svh"

module etx_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  localparam logic [4:0] FullLen = 5'(QUEUE_DEPTH);

  logic       m_stall, s_fire;
  logic       out_drop, out_sent, out_idle;
  logic [4:0] out_len;
  logic [1:0] out_state;

  assign m_stall   = m_axis_tvalid && !m_axis_tready;
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign out_len   = m_axis_tdata[12:8];
  assign out_state = m_axis_tdata[14:13];
  assign out_drop  = m_axis_tvalid && (m_axis_tuser == etx_pkg::EV_DROP);
  assign out_sent  = m_axis_tvalid && (m_axis_tuser == etx_pkg::EV_SENT);
  assign out_idle  = m_axis_tvalid && (out_state == etx_pkg::TXS_IDLE);

  `ETX_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))
  `ETX_ASSERT_NEXT(a_one_result, s_fire, m_axis_tvalid)
  `ETX_ASSERT_NOW(a_drop_full, out_drop, out_len == FullLen)
  `ETX_ASSERT_NOW(a_sent_gap, out_sent, out_state == etx_pkg::TXS_GAP)
  `ETX_ASSERT_NOW(a_idle_empty, out_idle, out_len == 5'd0)

endmodule

bind ethernet_tx_scheduler_ifg etx_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_etx_checker (.*);

// ===== verif/tb.sv =====
module tb;

  localparam int unsigned FifoDepth = 16;
  localparam int unsigned CycleLimit = 600000;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    etx_pkg::ev_e  res;
    logic [7:0]    tag;
    logic [4:0]    qlen;
    etx_pkg::txs_e state;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 32'd0;
  logic [1:0]  s_axis_tuser = 2'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  ethernet_tx_scheduler_ifg #(
    .QUEUE_DEPTH(FifoDepth)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predictor state of the transmit scheduler.
  logic [7:0]    fifo_tag [FifoDepth];
  logic [15:0]   fifo_bits [FifoDepth];
  logic [3:0]    fifo_head = '0;
  logic [4:0]    fifo_count = '0;
  etx_pkg::txs_e tx_mode = etx_pkg::TXS_IDLE;
  logic [15:0]   bits_left = '0;
  logic [7:0]    phase_cnt = '0;
  logic [7:0]    cur_tag = '0;
  logic [7:0]    bit_time = 8'd1;

  sched_result_t pending_events [$];
  sched_result_t head_r;
  int unsigned   fail_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   hold_req = 0;
  int unsigned   hold_left = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ethernet_tx_scheduler_ifg: mismatch");
      $finish;
    end
  end

  // The receiver's long hold-off is counted here, apart from the sender.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        $error("result transaction with no expectation waiting");
        fail_count++;
      end else begin
        head_r = pending_events.pop_front();
        if (m_axis_tuser !== head_r.res) begin
          $error("event_res expected %0d got %0d", head_r.res, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[7:0] !== head_r.tag) begin
          $error("event_tag expected %0d got %0d", head_r.tag, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[12:8] !== head_r.qlen) begin
          $error("queue_length expected %0d got %0d", head_r.qlen, m_axis_tdata[12:8]);
          fail_count++;
        end
        if (m_axis_tdata[14:13] !== head_r.state) begin
          $error("tx_state expected %0d got %0d", head_r.state, m_axis_tdata[14:13]);
          fail_count++;
        end
      end
    end
  end

  function automatic logic bit_time_done();
    logic [7:0] tpb;
    tpb = (bit_time == 8'd0) ? 8'd1 : bit_time;
    if (bits_left == 16'd0) return 1'b1;
    phase_cnt = phase_cnt + 8'd1;
    if (phase_cnt >= tpb) begin
      phase_cnt = 8'd0;
      bits_left = bits_left - 16'd1;
      if (bits_left == 16'd0) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void start_next_frame();
    phase_cnt = 8'd0;
    if (fifo_count != 5'd0) begin
      cur_tag = fifo_tag[fifo_head];
      bits_left = fifo_bits[fifo_head];
      fifo_head = fifo_head + 4'd1;
      fifo_count = fifo_count - 5'd1;
      tx_mode = etx_pkg::TXS_TX;
    end else begin
      bits_left = 16'd0;
      tx_mode = etx_pkg::TXS_IDLE;
    end
  endfunction

  function automatic sched_result_t sched_step(logic [1:0] op, logic [7:0] tag,
                                               logic [15:0] bits, logic err);
    sched_result_t r;
    logic [3:0]    tail;
    r.res = etx_pkg::EV_NONE;
    r.tag = 8'd0;
    case (op)
      etx_pkg::OP_TICK: begin
        if (tx_mode == etx_pkg::TXS_TX) begin
          if (bit_time_done()) begin
            r.res = etx_pkg::EV_SENT;
            r.tag = cur_tag;
            tx_mode = etx_pkg::TXS_GAP;
            bits_left = etx_pkg::GapBits;
            phase_cnt = 8'd0;
          end
        end else if (tx_mode == etx_pkg::TXS_GAP) begin
          if (bit_time_done()) start_next_frame();
        end
      end
      etx_pkg::OP_UPPER: begin
        if (fifo_count >= FifoDepth) begin
          r.res = etx_pkg::EV_DROP;
          r.tag = tag;
        end else begin
          tail = fifo_head + fifo_count[3:0];
          fifo_tag[tail] = tag;
          fifo_bits[tail] = bits;
          fifo_count = fifo_count + 5'd1;
          if (tx_mode == etx_pkg::TXS_IDLE) start_next_frame();
        end
      end
      etx_pkg::OP_CHANNEL: begin
        if (!err) begin
          r.res = etx_pkg::EV_UP;
          r.tag = tag;
        end
      end
      default: ;
    endcase
    r.qlen = fifo_count;
    r.state = tx_mode;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] tag,
                           input logic [15:0] bits, input logic err);
    int unsigned gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, err, bits, tag};
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_events.push_back(sched_step(op, tag, bits, err));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_item(etx_pkg::OP_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)),
              1'($urandom_range(1)));
  endtask

  task automatic send_noise();
    if ($urandom_range(9) == 0) begin
      send_item(OpUnused, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                1'($urandom_range(1)));
    end else begin
      send_item(etx_pkg::OP_CHANNEL, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                1'($urandom_range(1)));
    end
  endtask

  task automatic tick_until_idle();
    while (tx_mode != etx_pkg::TXS_IDLE) send_tick();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_bit_time(input logic [7:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    bit_time = value;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 47; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 47; end
      default: begin send_idle_pct = 20; stall_pct = 20; end
    endcase
  endtask

  task automatic test_idle_and_channel();
    set_idling(0);
    send_item(etx_pkg::OP_TICK, 8'd0, 16'd0, 1'b0);
    send_item(etx_pkg::OP_TICK, 8'hFF, 16'hFFFF, 1'b1);
    send_item(OpUnused, 8'hFF, 16'hFFFF, 1'b1);
    send_item(etx_pkg::OP_CHANNEL, 8'd0, 16'd0, 1'b0);
    send_item(etx_pkg::OP_CHANNEL, 8'hFF, 16'hFFFF, 1'b0);
    send_item(etx_pkg::OP_CHANNEL, 8'h3C, 16'hFFFF, 1'b1);
  endtask

  task automatic test_zero_length_frame();
    set_idling(0);
    send_item(etx_pkg::OP_UPPER, 8'h5A, 16'd0, 1'b0);
    send_item(etx_pkg::OP_UPPER, 8'h00, 16'd1, 1'b1);
    send_tick();
    tick_until_idle();
  endtask

  task automatic test_backpressure();
    set_idling(0);
    hold_req = 80;
    send_item(etx_pkg::OP_UPPER, 8'h11, 16'd3, 1'b0);
    repeat (40) send_tick();
    wait_drained();
    tick_until_idle();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [7:0]  phase_tpb [8];
    int unsigned phase_len [8];
    int unsigned stop_at;
    int unsigned k;
    int unsigned n;
    phase_tpb = '{8'd2, 8'd255, 8'd1, 8'd0, 8'd3, 8'd1, 8'd4, 8'd1};
    phase_len = '{230, 120, 240, 220, 230, 240, 220, 250};
    for (int p = 0; p < 8; p++) begin
      set_bit_time(phase_tpb[p]);
      set_idling(p % 4);
      stop_at = items_sent + phase_len[p];
      while (items_sent < stop_at) begin
        k = ($urandom_range(14) == 0) ? $urandom_range(8, 18) : $urandom_range(1, 3);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(3) == 0) send_noise();
          send_item(etx_pkg::OP_UPPER, 8'($urandom_range(255)),
                    ($urandom_range(9) == 0) ? 16'($urandom_range(200))
                                             : 16'($urandom_range(16)),
                    1'($urandom_range(1)));
        end
        n = $urandom_range(50, 400);
        for (int i = 0; i < n && items_sent < stop_at; i++) begin
          if ($urandom_range(19) == 0) send_noise();
          else send_tick();
        end
      end
    end
    set_idling(3);
    tick_until_idle();
  endtask

  task automatic test_long_frame_and_full_queue();
    set_idling(0);
    send_item(etx_pkg::OP_UPPER, 8'hFF, 16'hFFFF, 1'b0);
    send_tick();
    send_tick();
    for (int i = 0; i < FifoDepth; i++) begin
      send_item(etx_pkg::OP_UPPER, 8'(i + 1), 16'($urandom_range(16)), 1'b0);
    end
    send_item(etx_pkg::OP_UPPER, 8'h00, 16'hFFFF, 1'b1);
    send_item(etx_pkg::OP_UPPER, 8'hFF, 16'd0, 1'b0);
    send_tick();
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_idle_and_channel();
    test_zero_length_frame();
    test_backpressure();
    test_random_traffic();
    set_bit_time(8'd1);
    test_long_frame_and_full_queue();
    wait_drained();
    repeat (5) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ethernet_tx_scheduler_ifg: match");
    end else begin
      $display("ethernet_tx_scheduler_ifg: mismatch");
    end
    $finish;
  end

endmodule
